[sv/lpwm_pkg.sv]
// Package for the LED PWM soft-start ramp: payload types, register map and reset values.
package lpwm_pkg;

  localparam int NumCh = 4;

  // Register indices on the configuration port
  typedef enum logic [1:0] {
    REG_PERIOD   = 2'd0,
    REG_CASCADE  = 2'd1,
    REG_SLOWZONE = 2'd2,
    REG_FASTSTEP = 2'd3
  } lpwm_reg_t;

  // Item operations
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CMD  = 1'b1;

  // Command bytes
  localparam logic [7:0] CMD_RELEASE = 8'h00;
  localparam logic [7:0] CMD_HOLD    = 8'h01;

  // Reset values
  localparam logic [15:0] PERIOD_RST   = 16'd500;
  localparam logic [7:0]  CASCADE_RST  = 8'h40;
  localparam logic [7:0]  SLOWZONE_RST = 8'h23;
  localparam logic [7:0]  FASTSTEP_RST = 8'h03;
  localparam logic [7:0]  DUTY_RST     = 8'h90;
  localparam logic [7:0]  DUTY_MAX     = 8'hff;
  localparam logic [15:0] COUNT_MAX    = 16'hffff;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
    logic       ramp_up;
  } lpwm_in_t;

  typedef struct packed {
    logic [7:0] duty_ch0;
    logic [7:0] duty_ch1;
    logic [7:0] duty_ch2;
    logic [7:0] duty_ch3;
    logic       full_on_ch0;
    logic       full_on_ch1;
    logic       full_on_ch2;
    logic       full_on_ch3;
    logic       held;
  } lpwm_out_t;

  typedef struct packed {
    logic [15:0] period;
    logic [7:0]  cascade;
    logic [7:0]  slow_zone;
    logic [7:0]  fast_step;
  } lpwm_cfg_t;

  // One falling step of a channel
  function automatic logic [7:0] fall_step(input logic [7:0] v, input logic [7:0] slow,
                                           input logic [7:0] fast);
    logic [7:0] r;
    if (v >= slow) begin
      r = (v >= fast) ? v - fast : 8'd0;
    end else begin
      r = (v != 8'd0) ? v - 8'd1 : 8'd0;
    end
    return r;
  endfunction

  // Saturating rise by one when enabled
  function automatic logic [7:0] rise_step(input logic [7:0] v, input logic en);
    return (en && v != DUTY_MAX) ? v + 8'd1 : v;
  endfunction

endpackage

[sv/lpwm_cfg.sv]
// Configuration register file on the APB-style port.
module lpwm_cfg
  import lpwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output lpwm_cfg_t   cfg
);

  logic      wr_en;
  lpwm_reg_t idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = lpwm_reg_t'(paddr[3:2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period    <= PERIOD_RST;
      cfg.cascade   <= CASCADE_RST;
      cfg.slow_zone <= SLOWZONE_RST;
      cfg.fast_step <= FASTSTEP_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_PERIOD:   cfg.period    <= pwdata[15:0];
        REG_CASCADE:  cfg.cascade   <= pwdata[7:0];
        REG_SLOWZONE: cfg.slow_zone <= pwdata[7:0];
        REG_FASTSTEP: cfg.fast_step <= pwdata[7:0];
        default:      ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    unique case (idx)
      REG_PERIOD:   prdata = {16'd0, cfg.period};
      REG_CASCADE:  prdata = {24'd0, cfg.cascade};
      REG_SLOWZONE: prdata = {24'd0, cfg.slow_zone};
      REG_FASTSTEP: prdata = {24'd0, cfg.fast_step};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

[sv/lpwm_core.sv]
// Ramp state and its single-pass update for one item.
module lpwm_core
  import lpwm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  lpwm_cfg_t cfg,
  input  logic      advance,
  input  lpwm_in_t  item,
  output lpwm_out_t result
);

  logic [15:0]            tick_count, tick_count_next, tick_inc;
  logic [NumCh-1:0][7:0]  duty, duty_next;
  logic [NumCh-1:0]       full_on, full_on_next;
  logic                   hold, hold_next;
  logic                   step;
  logic [7:0]             up1, up3, up0;

  // Tick counter, saturating just past the threshold
  assign tick_inc = (tick_count <= cfg.period && tick_count != COUNT_MAX) ?
                    tick_count + 16'd1 : tick_count;
  assign step     = (tick_inc > cfg.period) && !hold;

  // Cascaded rise: ch1 leads, ch3 follows ch1, ch0 follows ch3
  assign up1 = rise_step(duty[1], 1'b1);
  assign up3 = rise_step(duty[3], up1 > cfg.cascade);
  assign up0 = rise_step(duty[0], up3 > cfg.cascade);

  always_comb begin
    tick_count_next = tick_count;
    duty_next       = duty;
    full_on_next    = full_on;
    hold_next       = hold;
    if (item.operation == OP_TICK) begin
      tick_count_next = step ? 16'd0 : tick_inc;
      if (step) begin
        if (item.ramp_up) begin
          duty_next[0] = up0;
          duty_next[1] = up1;
          duty_next[3] = up3;
          for (int c = 0; c < NumCh; c++) begin
            full_on_next[c] = full_on[c] | (duty_next[c] == DUTY_MAX);
          end
        end else begin
          for (int c = 0; c < NumCh; c++) begin
            duty_next[c]    = fall_step(duty[c], cfg.slow_zone, cfg.fast_step);
            full_on_next[c] = 1'b0;
          end
        end
      end
    end else begin
      priority if (item.rx_byte == CMD_RELEASE) begin
        hold_next = 1'b0;
      end else if (item.rx_byte == CMD_HOLD) begin
        hold_next = 1'b1;
      end else begin
        duty_next[2] = item.rx_byte;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= 16'd0;
      duty       <= {NumCh{DUTY_RST}};
      full_on    <= '0;
      hold       <= 1'b0;
    end else if (advance) begin
      tick_count <= tick_count_next;
      duty       <= duty_next;
      full_on    <= full_on_next;
      hold       <= hold_next;
    end
  end

  // Result is the state after the update
  assign result = '{duty_ch0:    duty_next[0],
                    duty_ch1:    duty_next[1],
                    duty_ch2:    duty_next[2],
                    duty_ch3:    duty_next[3],
                    full_on_ch0: full_on_next[0],
                    full_on_ch1: full_on_next[1],
                    full_on_ch2: full_on_next[2],
                    full_on_ch3: full_on_next[3],
                    held:        hold_next};

endmodule

[sv/led_pwm_soft_start_ramp.sv]
// Top level of the four-channel LED PWM soft-start ramp.
//
//   channel | handshake         | payload
//   --------+-------------------+------------------------------
//   in      | in_valid/in_ready | in_data   (lpwm_in_t)
//   out     | out_valid/out_ready| out_data (lpwm_out_t)
//   cfg     | psel/penable      | paddr, pwdata, prdata
//
// Input register, then result register; one item per cycle unless out stalls.
// The input register feeds the state update; the result register holds the
// outcome, so a new item is taken while a result waits.
// A stalled output freezes the input register and drops in_ready only when
// both registers are full. Reset clears both valid flags and all ramp state.
module led_pwm_soft_start_ramp
  import lpwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  lpwm_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output lpwm_out_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lpwm_cfg_t cfg;
  lpwm_in_t  item;
  logic      item_valid;
  logic      advance;
  lpwm_out_t result;

  assign pready   = 1'b1;
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  lpwm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  lpwm_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .item    (item),
    .result  (result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  // A hold command shows in the very next result
  a_hold_cmd: assert property (@(posedge clk) disable iff (rst)
    advance && item.operation == OP_CMD && item.rx_byte == CMD_HOLD |=> out_data.held)
    else $error("hold command not reflected in result");

  // Backpressure only when the input register is occupied
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> item_valid && out_valid && !out_ready)
    else $error("in_ready low without a full pipeline");

  // Every transfer out of the input register yields a result
  a_advance: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result lost");

  // Reset empties both registers
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !item_valid)
    else $error("valid flags not cleared by reset");
`endif

endmodule
